### hw/rtl/fvis_pkg.sv
// Shared types, codes and constants of the frame varint item serializer.
`timescale 1ns / 1ps
`default_nettype none

package fvis_pkg;

  // Operation codes of an input item
  localparam logic [2:0] OP_FRAME_START = 3'd0;
  localparam logic [2:0] OP_RAW_BYTE    = 3'd1;
  localparam logic [2:0] OP_VARINT      = 3'd2;
  localparam logic [2:0] OP_STR_LEN     = 3'd3;
  localparam logic [2:0] OP_STR_BYTE    = 3'd4;
  localparam logic [2:0] OP_END         = 3'd5;

  localparam int unsigned POSITION_BITS_DEFAULT = 16;
  localparam logic [15:0] MAX_FRAME_RESET       = 16'd16384;

  // Byte count of a frame start: kind byte plus the four bytes of the item value
  localparam logic [2:0] FRAME_HEADER_BYTES = 3'd5;

  // Varint prefix markers
  localparam logic [7:0] VARINT_FIRST_MARK = 8'd240;
  localparam logic [7:0] VARINT_CONT_MARK  = 8'd128;

  // Smallest value that needs 2, 3, 4 and 5 bytes
  localparam logic [31:0] VARINT_LEN2_MIN = 32'd240;
  localparam logic [31:0] VARINT_LEN3_MIN = 32'd2288;
  localparam logic [31:0] VARINT_LEN4_MIN = 32'd264432;
  localparam logic [31:0] VARINT_LEN5_MIN = 32'd33818864;

  typedef struct packed {
    logic load;   // take a new item
    logic check;  // budget check and state update
    logic emit;   // produce one result beat
  } fvis_cmd_t;

  typedef struct packed {
    logic slot_free;    // output register can take a beat
    logic last_result;  // the next beat is the item's last
  } fvis_status_t;

  function automatic logic [2:0] varint_len(input logic [31:0] value);
    logic [2:0] len;
    if (value < VARINT_LEN2_MIN) begin
      len = 3'd1;
    end else if (value < VARINT_LEN3_MIN) begin
      len = 3'd2;
    end else if (value < VARINT_LEN4_MIN) begin
      len = 3'd3;
    end else if (value < VARINT_LEN5_MIN) begin
      len = 3'd4;
    end else begin
      len = 3'd5;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/frame_varint_item_serializer.sv
// Top level of the frame varint item serializer.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  operation_i, item_value_i, frame_kind_i
//   out      output     out_valid_o/out_ready_i out_byte_o, byte_valid_o, run_last_o,
//                                              error_flag_o, frame_length_o
//   cfg      input      cfg_we_i               cfg_wdata_i (max_frame_bytes)
//
// An item passes a load step and a budget-check step, then emits one result beat per
// cycle while the output register can take one; a frame start or a five-byte varint
// gives five beats. The output register sets the pace of the emit phase; a stalled out
// channel holds the beat and the controller waits. The next item is accepted as soon
// as the last beat of the previous one sits in the output register.
// Reset restores max_frame_bytes to 16384 and clears position and error.
`timescale 1ns / 1ps
`default_nettype none

module frame_varint_item_serializer
  import fvis_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [31:0] item_value_i,
  input  wire logic [7:0]  frame_kind_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             run_last_o,
  output logic             error_flag_o,
  output logic [15:0]      frame_length_o
);

  fvis_cmd_t    cmd;
  fvis_status_t status;

  fvis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fvis_datapath #(
    .PositionBits (POSITION_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .item_value_i   (item_value_i),
    .frame_kind_i   (frame_kind_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .run_last_o     (run_last_o),
    .error_flag_o   (error_flag_o),
    .frame_length_o (frame_length_o)
  );

endmodule

`default_nettype wire

### hw/rtl/fvis_ctrl.sv
// Controller state machine: load, check, then one result beat per cycle while the output slot is free.
`timescale 1ns / 1ps
`default_nettype none

module fvis_ctrl
  import fvis_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire fvis_status_t status_i,
  output fvis_cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_result) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fvis_datapath.sv
// Datapath: item registers, frame budget check, byte encoder and output register.
`timescale 1ns / 1ps
`default_nettype none

module fvis_datapath
  import fvis_pkg::*;
#(
  parameter int unsigned PositionBits = POSITION_BITS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic [2:0]  operation_i,
  input  wire logic [31:0] item_value_i,
  input  wire logic [7:0]  frame_kind_i,
  input  wire fvis_cmd_t   cmd_i,
  output fvis_status_t     status_o,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             run_last_o,
  output logic             error_flag_o,
  output logic [15:0]      frame_length_o
);

  // Wide enough for position + count + 32-bit string length, and for the cap
  localparam int unsigned CmpW = ((PositionBits > 33) ? PositionBits : 33) + 1;
  localparam logic [CmpW-1:0] CapLimit = (CmpW'(1) << PositionBits) - CmpW'(1);

  logic [15:0]             max_frame_q;
  logic [PositionBits-1:0] pos_q;
  logic                    err_q;
  logic [2:0]              op_q;
  logic [31:0]             val_q;
  logic [7:0]              kind_q;
  logic [31:0]             cur_v_q;
  logic [2:0]              count_q;
  logic [2:0]              idx_q;
  logic                    null_q;

  logic                    out_valid_q;
  logic [7:0]              out_byte_q;
  logic                    byte_valid_q;
  logic                    run_last_q;
  logic                    error_flag_q;
  logic [15:0]             frame_length_q;

  // Item load
  logic [2:0] count_d;

  always_comb begin
    case (operation_i)
      OP_FRAME_START: count_d = FRAME_HEADER_BYTES;
      OP_RAW_BYTE:    count_d = 3'd1;
      OP_STR_BYTE:    count_d = 3'd1;
      OP_VARINT:      count_d = varint_len(item_value_i);
      OP_STR_LEN:     count_d = varint_len(item_value_i);
      default:        count_d = 3'd0;
    endcase
  end

  // Budget check
  logic                    is_start;
  logic [PositionBits-1:0] pos_eff;
  logic                    err_eff;
  logic [CmpW-1:0]         limit;
  logic [CmpW-1:0]         need_sum;
  logic                    fits;

  assign is_start = (op_q == OP_FRAME_START);
  assign pos_eff  = is_start ? '0 : pos_q;
  assign err_eff  = is_start ? 1'b0 : err_q;
  assign limit    = (CmpW'(max_frame_q) < CapLimit) ? CmpW'(max_frame_q) : CapLimit;
  assign need_sum = CmpW'(pos_eff) + CmpW'(count_q)
                  + ((op_q == OP_STR_LEN) ? CmpW'(val_q) : '0);
  assign fits     = (need_sum <= limit);

  // Byte encoder
  logic       last_byte;
  logic [7:0] enc_byte;
  logic [31:0] cur_v_next;

  assign last_byte = (idx_q == (count_q - 3'd1));

  always_comb begin
    enc_byte   = val_q[7:0];
    cur_v_next = cur_v_q;
    case (op_q)
      OP_FRAME_START: begin
        case (idx_q)
          3'd0:    enc_byte = kind_q;
          3'd1:    enc_byte = val_q[31:24];
          3'd2:    enc_byte = val_q[23:16];
          3'd3:    enc_byte = val_q[15:8];
          default: enc_byte = val_q[7:0];
        endcase
      end
      OP_VARINT, OP_STR_LEN: begin
        if (last_byte) begin
          enc_byte = cur_v_q[7:0];
        end else if (idx_q == 3'd0) begin
          enc_byte   = cur_v_q[7:0] | VARINT_FIRST_MARK;
          cur_v_next = (cur_v_q - 32'(VARINT_FIRST_MARK)) >> 4;
        end else begin
          enc_byte   = cur_v_q[7:0] | VARINT_CONT_MARK;
          cur_v_next = (cur_v_q - 32'(VARINT_CONT_MARK)) >> 7;
        end
      end
      default: begin
        enc_byte = val_q[7:0];
      end
    endcase
  end

  logic [PositionBits-1:0] pos_inc;
  logic [CmpW-1:0]         pos_inc_ext;
  logic [CmpW-1:0]         pos_ext;

  assign pos_inc     = pos_q + PositionBits'(1);
  assign pos_inc_ext = CmpW'(pos_inc);
  assign pos_ext     = CmpW'(pos_q);

  assign status_o.slot_free   = !out_valid_q || out_ready_i;
  assign status_o.last_result = null_q || last_byte;

  // Control-state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= MAX_FRAME_RESET;
      pos_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_frame_q <= cfg_wdata_i;
      end
      if (cmd_i.check) begin
        pos_q <= pos_eff;
        err_q <= err_eff | ((count_q != 3'd0) && !err_eff && !fits);
      end else if (cmd_i.emit && !null_q) begin
        pos_q <= pos_inc;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      val_q   <= item_value_i;
      kind_q  <= frame_kind_i;
      cur_v_q <= item_value_i;
      count_q <= count_d;
      idx_q   <= '0;
    end
    if (cmd_i.check) begin
      null_q <= (count_q == 3'd0) || err_eff || !fits;
    end
    if (cmd_i.emit) begin
      idx_q   <= idx_q + 3'd1;
      cur_v_q <= cur_v_next;
      if (null_q) begin
        out_byte_q     <= '0;
        byte_valid_q   <= 1'b0;
        run_last_q     <= 1'b1;
        frame_length_q <= pos_ext[15:0];
      end else begin
        out_byte_q     <= enc_byte;
        byte_valid_q   <= 1'b1;
        run_last_q     <= last_byte;
        frame_length_q <= pos_inc_ext[15:0];
      end
      error_flag_q <= err_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign byte_valid_o   = byte_valid_q;
  assign run_last_o     = run_last_q;
  assign error_flag_o   = error_flag_q;
  assign frame_length_o = frame_length_q;

endmodule

`default_nettype wire
